// ===== rtl/counting_semaphore_wait_queue_unit_macros.svh =====
// Assertion macros for the counting semaphore wait queue unit.
// Used by the checker; depends on nothing.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_MACROS_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_MACROS_SVH

// Condition in one cycle implies a condition in the same cycle.
`define CSQ_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define CSQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/csq_pkg.sv =====
// Shared types and constants of the counting semaphore wait queue unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package csq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = 9;
  localparam int INIT_W      = 8;
  localparam int SUM_W       = CNT_W + 1;

  localparam logic signed [CNT_W-1:0] CNT_MAX   = 9'sd255;
  localparam logic signed [CNT_W-1:0] CNT_RESET = 9'sd1;

  typedef enum logic [1:0] {
    STATUS_GRANTED = 2'd0,
    STATUS_QUEUED  = 2'd1,
    STATUS_REFUSED = 2'd2,
    STATUS_SIGNAL  = 2'd3
  } csq_status_e;

  // Request from the control logic to the wait queue memory.
  typedef struct packed {
    logic               we;
    logic [PTR_W-1:0]   waddr;
    logic [ID_BITS-1:0] wdata;
    logic               re;
    logic [PTR_W-1:0]   raddr;
  } csq_mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/csq_queue_mem.sv =====
// Wait queue storage: one write port, one read port with registered data.
// Depends on csq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csq_queue_mem
  import csq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire csq_mem_req_t       req_i,
  output logic      [ID_BITS-1:0] rdata_o
);

  logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/counting_semaphore_wait_queue_unit.sv =====
// Top level of the counting semaphore wait queue unit.
// Depends on csq_pkg and csq_queue_mem.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: op_i (0 wait,
//   1 signal) and requester_id_i. Output channel (out_valid_o / out_stall_i)
//   returns one result per item: status_o, wake_valid_o, wake_id_o.
//   An item moves at a rising edge where valid is high and stall is low.
//   A wait, or a signal that wakes nobody, has its result in the output
//   register in the cycle after acceptance and the next item may enter in
//   that same cycle: one item per cycle while out_stall_i is low.
//   A signal that wakes a waiter reads the oldest id from the queue memory
//   (registered read data), so its result passes through ST_READ and then the
//   output register, and the input is stalled while in ST_READ: no new item
//   enters before that result is loaded.
//   While a result waits with out_stall_i high, a new item is taken only
//   once that result leaves; the held result does not change.
//   Reset sets the count to 1 and empties the queue; queue entries are not
//   cleared. Writing cfg_wdata_i with cfg_we_i reloads the count and empties
//   the queue; write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_wait_queue_unit
  import csq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [ID_BITS-1:0] requester_id_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [1:0]         status_o,
  output logic                    wake_valid_o,
  output logic      [ID_BITS-1:0] wake_id_o,
  input  wire logic               cfg_we_i,
  input  wire logic [INIT_W-1:0]  cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } csq_state_e;

  csq_state_e state_q, state_d;

  logic signed [CNT_W-1:0] cnt_q, cnt_d;
  logic        [PTR_W-1:0] head_q, head_d;

  logic                    out_valid_q, out_valid_d;
  csq_status_e             out_status_q, out_status_d;
  logic                    out_wake_q, out_wake_d;
  logic      [ID_BITS-1:0] out_id_q, out_id_d;

  csq_mem_req_t            mem_req;
  logic      [ID_BITS-1:0] mem_rdata;

  logic                    out_free;
  logic                    accept;
  logic        [CNT_W-1:0] waiting;
  logic        [SUM_W-1:0] tail_sum;
  logic        [SUM_W-1:0] tail_wrap;
  logic        [PTR_W-1:0] tail;
  logic        [PTR_W-1:0] head_inc;

  csq_queue_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  // Interlock: no new item while a wake-up read is outstanding.
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Number of queued waiters when the count is not positive.
  assign waiting   = CNT_W'(-cnt_q);
  assign tail_sum  = SUM_W'(head_q) + SUM_W'(waiting);
  assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                       : tail_sum;
  assign tail      = tail_wrap[PTR_W-1:0];
  assign head_inc  = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    head_d       = head_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_wake_d   = out_wake_q;
    out_id_d     = out_id_q;
    mem_req      = '0;
    mem_req.waddr = tail;
    mem_req.wdata = requester_id_i;
    mem_req.raddr = head_q;

    unique case (state_q)
      ST_READ: begin
        // Read data for the woken waiter is now valid.
        out_valid_d  = 1'b1;
        out_status_d = STATUS_SIGNAL;
        out_wake_d   = 1'b1;
        out_id_d     = mem_rdata;
        state_d      = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          out_wake_d = 1'b0;
          out_id_d   = '0;
          if (!op_i) begin
            out_valid_d = 1'b1;
            if (cnt_q > $signed(CNT_W'(0))) begin
              cnt_d        = cnt_q - CNT_W'(1);
              out_status_d = STATUS_GRANTED;
            end else if (waiting >= CNT_W'(QUEUE_DEPTH)) begin
              out_status_d = STATUS_REFUSED;
            end else begin
              mem_req.we   = 1'b1;
              cnt_d        = cnt_q - CNT_W'(1);
              out_status_d = STATUS_QUEUED;
            end
          end else begin
            if (cnt_q < 0) begin
              mem_req.re = 1'b1;
              head_d     = head_inc;
              state_d    = ST_READ;
            end else begin
              out_valid_d  = 1'b1;
              out_status_d = STATUS_SIGNAL;
            end
            if (cnt_q < CNT_MAX) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      cnt_d  = $signed({1'b0, cfg_wdata_i});
      head_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= CNT_RESET;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_wake_q   <= out_wake_d;
    out_id_q     <= out_id_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign wake_valid_o = out_wake_q;
  assign wake_id_o    = out_id_q;

endmodule

`default_nettype wire

// ===== rtl/csq_checker.sv =====
// Port-level checks of the counting semaphore wait queue unit, bound to the top.
// Depends on csq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "counting_semaphore_wait_queue_unit_macros.svh"

module csq_checker
  import csq_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               op_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [1:0]         status_o,
  input wire logic               wake_valid_o,
  input wire logic [ID_BITS-1:0] wake_id_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // Hold a stalled result.
  `CSQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(wake_valid_o) && $stable(wake_id_o),
    "stalled result changed")

  // A pending, stalled result must block the input.
  `CSQ_ASSERT_NOW(a_in_blocked, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o,
    "item accepted while result is stalled")

  // A wait answers in the next cycle, never with a wake-up.
  `CSQ_ASSERT_NEXT(a_wait_result, clk_i, rst_ni, in_acc && !op_i,
    out_valid_o && status_o != STATUS_SIGNAL && !wake_valid_o,
    "wait item gave no wait result")

  // A signal answers without a queue read, or stalls the input while the queue is read.
  `CSQ_ASSERT_NEXT(a_signal_result, clk_i, rst_ni, in_acc && op_i,
    (out_valid_o && status_o == STATUS_SIGNAL && !wake_valid_o) || (in_stall_o && !out_valid_o),
    "signal item gave wrong result")

  // Idle wake-up fields read as zero.
  `CSQ_ASSERT_NOW(a_wake_zero, clk_i, rst_ni, out_valid_o && !wake_valid_o,
    wake_id_o == '0, "wake id not zero without wake-up")

endmodule

bind counting_semaphore_wait_queue_unit csq_checker u_csq_checker (.*);

`default_nettype wire
